@@ sv/icmu_pkg.sv @@
// Shared types and constants of the Ising chain Metropolis update unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package icmu_pkg;

  // Fixed field and register widths.
  localparam int SITE_W      = 10;
  localparam int RAND_IN_W   = 32;
  localparam int THRESH_W    = 33;
  localparam int CHAIN_W     = 11;
  localparam int MAGN_W      = 12;
  localparam int CFG_ADDR_W  = 3;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 24;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] CFG_CHAIN_LENGTH   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_UPDATE_MODE    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ACCEPT_ALIGNED = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_ACCEPT_MIXED   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_ACCEPT_ANTI    = 3'd4;

  // Request kinds carried in in_tuser.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_TRIAL = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [CHAIN_W-1:0]  CHAIN_LEN_RST = 11'd1024;
  localparam logic [THRESH_W-1:0] THRESH_ZERO   = 33'h0_0000_0000;
  localparam logic [THRESH_W-1:0] THRESH_ONE    = 33'h1_0000_0000;

  // Status of the serial remainder unit.
  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

endpackage

`default_nettype wire

@@ sv/icmu_mod_unit.sv @@
// Serial remainder unit: one restoring step per cycle, one dividend bit a step.
// Depends on icmu_pkg for the status struct.
`default_nettype none

module icmu_mod_unit #(
  parameter int DVD_W = 32,
  parameter int DIV_W = 11
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [DVD_W-1:0]    dividend,
  input  wire logic [DIV_W-1:0]    divisor,
  output icmu_pkg::mod_stat_t      stat,
  output logic [DIV_W-1:0]         rem
);
  import icmu_pkg::*;

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_r;
  logic [DIV_W-1:0] div_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] rem_nxt;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DIV_W:0]   trial;

  // The partial remainder stays below the divisor, so one subtract suffices.
  always_comb begin
    trial = {rem_r, dvd_r[DVD_W-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = DIV_W'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = DIV_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(DVD_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign rem       = rem_r;

`ifndef SYNTHESIS
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < div_r))
    else $error("remainder not below divisor at completion");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("unit not busy after start");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("completion without a preceding run");
`endif

endmodule

`default_nettype wire

@@ sv/ising_chain_metropolis_update_unit.sv @@
// Top level of the Ising chain Metropolis update unit: spin memory, sequencer,
// configuration registers and output register. Depends on icmu_pkg, icmu_mod_unit.
//
//   Channel  Dir  Handshake                Payload
//   in_      in   in_tvalid / in_tready    in_tdata: load/trial fields, in_tuser: kind
//   out_     out  out_tvalid / out_tready  out_tdata: result fields, out_tuser: status
//   cfg_     in   cfg_we (no wait)         cfg_addr register index, cfg_wdata value
//
// A random-site trial waits for the serial remainder unit, then reads the site and
// its two neighbors and decides; a sequential trial does only the reads and decision,
// and a load reads and writes its site (neither when the site is outside the chain).
// Spin memory reads are issued one a cycle. After reset a clearing pass writes every
// site; writing chain_length while idle or recounting starts a recount of down spins
// over the chain; in_tready is low in both. The output register lets the next request
// in while a result waits; a result stalls only if the previous one is still unread.
`default_nettype none

module ising_chain_metropolis_update_unit #(
  parameter int MAX_SITES   = 1024,
  parameter int RANDOM_BITS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // load_site[9:0], load_down[10], site_random[42:11], accept_random[74:43], zeros
  input  wire logic [icmu_pkg::IN_TDATA_W-1:0]   in_tdata,
  // kind[0]
  input  wire logic                              in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // site[9:0], spin_down[10], flipped[11], magnetization[23:12]
  output logic [icmu_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // status[0]
  output logic                                   out_tuser,
  input  wire logic                              cfg_we,
  input  wire logic [icmu_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [icmu_pkg::THRESH_W-1:0]     cfg_wdata
);
  import icmu_pkg::*;

  localparam int SW = $clog2(MAX_SITES);
  localparam int LW = $clog2(MAX_SITES + 1);
  localparam int RW = (RANDOM_BITS < RAND_IN_W) ? RANDOM_BITS : RAND_IN_W;
  localparam int MW = LW + 2;

  typedef enum logic [10:0] {
    S_CLEAR   = 11'b000_0000_0001,
    S_IDLE    = 11'b000_0000_0010,
    S_RECOUNT = 11'b000_0000_0100,
    S_MOD     = 11'b000_0000_1000,
    S_LOAD_RD = 11'b000_0001_0000,
    S_LOAD_WR = 11'b000_0010_0000,
    S_RD_ME   = 11'b000_0100_0000,
    S_RD_L    = 11'b000_1000_0000,
    S_RD_R    = 11'b001_0000_0000,
    S_DECIDE  = 11'b010_0000_0000,
    S_DONE    = 11'b100_0000_0000
  } state_t;

  // Configuration registers.
  logic [CHAIN_W-1:0]  chain_len_r;
  logic                mode_r;
  logic [THRESH_W-1:0] thr_aligned_r;
  logic [THRESH_W-1:0] thr_mixed_r;
  logic [THRESH_W-1:0] thr_anti_r;

  // Control state.
  state_t         state_r, state_nxt;
  logic [LW-1:0]  cnt_r, cnt_nxt;
  logic           rc_pend_r, rc_pend_nxt;
  logic [LW-1:0]  dc_r, dc_nxt;
  logic [SW-1:0]  next_site_r, next_site_nxt;
  logic           out_tvalid_r, out_tvalid_nxt;

  // Request and working payload.
  logic                kind_r, kind_nxt;
  logic [SITE_W-1:0]   load_site_r, load_site_nxt;
  logic                load_down_r, load_down_nxt;
  logic [RW-1:0]       acc_r, acc_nxt;
  logic [SW-1:0]       site_r, site_nxt;
  logic                me_r, me_nxt;
  logic                al_l_r, al_l_nxt;
  logic                spin_r, spin_nxt;
  logic                flip_r, flip_nxt;
  logic                stat_r, stat_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                out_tuser_r;

  // Spin memory.
  logic          spin_mem [MAX_SITES];
  logic          rd_data_r;
  logic          mem_we;
  logic [SW-1:0] mem_wa;
  logic          mem_wd;
  logic [SW-1:0] mem_ra;

  logic [LW-1:0]       n_eff;
  logic [SW-1:0]       left_site;
  logic [SW-1:0]       right_site;
  logic [LW-1:0]       site_inc;
  logic                in_acc;
  logic                out_ld;
  logic                chain_wr;
  logic                mod_start;
  mod_stat_t           mod_stat;
  logic [LW-1:0]       mod_rem;
  logic signed [MW-1:0] magn;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_ld    = (state_r == S_DONE) && (!out_tvalid_r || out_tready);
  assign chain_wr  = cfg_we && (cfg_addr == CFG_CHAIN_LENGTH);
  assign mod_start = in_acc && (in_tuser == KIND_TRIAL) && mode_r;

  always_comb begin
    if (chain_len_r < 11'd3) begin
      n_eff = LW'(32'd3);
    end else if (32'(chain_len_r) > MAX_SITES) begin
      n_eff = LW'(MAX_SITES);
    end else begin
      n_eff = LW'(chain_len_r);
    end
  end

  // Periodic neighbors of the current site.
  assign site_inc   = LW'(site_r) + 1'b1;
  assign left_site  = (site_r == '0) ? SW'(n_eff - 1'b1) : site_r - 1'b1;
  assign right_site = (site_inc == n_eff) ? '0 : SW'(site_inc);

  assign magn = $signed({2'b00, n_eff}) - $signed({1'b0, dc_r, 1'b0});

  icmu_mod_unit #(
    .DVD_W (RW),
    .DIV_W (LW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (RW'(in_tdata[42:11])),
    .divisor  (n_eff),
    .stat     (mod_stat),
    .rem      (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_len_r   <= CHAIN_LEN_RST;
      mode_r        <= 1'b0;
      thr_aligned_r <= THRESH_ZERO;
      thr_mixed_r   <= THRESH_ONE;
      thr_anti_r    <= THRESH_ONE;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_CHAIN_LENGTH:   chain_len_r   <= cfg_wdata[CHAIN_W-1:0];
        CFG_UPDATE_MODE:    mode_r        <= cfg_wdata[0];
        CFG_ACCEPT_ALIGNED: thr_aligned_r <= cfg_wdata;
        CFG_ACCEPT_MIXED:   thr_mixed_r   <= cfg_wdata;
        CFG_ACCEPT_ANTI:    thr_anti_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [LW-1:0]       seq_site;
    logic [1:0]          aligned;
    logic [THRESH_W-1:0] thr;
    logic                al_r;
    logic                flip;

    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    rc_pend_nxt    = rc_pend_r;
    dc_nxt         = dc_r;
    next_site_nxt  = next_site_r;
    kind_nxt       = kind_r;
    load_site_nxt  = load_site_r;
    load_down_nxt  = load_down_r;
    acc_nxt        = acc_r;
    site_nxt       = site_r;
    me_nxt         = me_r;
    al_l_nxt       = al_l_r;
    spin_nxt       = spin_r;
    flip_nxt       = flip_r;
    stat_nxt       = stat_r;
    mem_we         = 1'b0;
    mem_wa         = site_r;
    mem_wd         = 1'b0;
    mem_ra         = site_r;
    seq_site       = (LW'(next_site_r) < n_eff) ? LW'(next_site_r) : '0;
    al_r           = (rd_data_r == me_r);
    aligned        = {1'b0, al_l_r} + {1'b0, al_r};
    thr            = thr_anti_r;
    if (aligned == 2'd2) begin
      thr = thr_aligned_r;
    end else if (aligned == 2'd1) begin
      thr = thr_mixed_r;
    end
    flip           = (THRESH_W'(acc_r) < thr);

    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = cnt_r[SW-1:0];
        mem_wd = 1'b0;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LW'(MAX_SITES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (chain_wr) begin
          cnt_nxt     = '0;
          rc_pend_nxt = 1'b0;
          dc_nxt      = '0;
          state_nxt   = S_RECOUNT;
        end else if (in_acc) begin
          kind_nxt      = in_tuser;
          load_site_nxt = in_tdata[9:0];
          load_down_nxt = in_tdata[10];
          acc_nxt       = RW'(in_tdata[74:43]);
          flip_nxt      = 1'b0;
          stat_nxt      = 1'b0;
          if (in_tuser == KIND_LOAD) begin
            if (32'(in_tdata[9:0]) >= 32'(n_eff)) begin
              spin_nxt  = 1'b0;
              stat_nxt  = 1'b1;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_LOAD_RD;
            end
          end else if (mode_r) begin
            state_nxt = S_MOD;
          end else begin
            site_nxt      = SW'(seq_site);
            next_site_nxt = (seq_site + 1'b1 == n_eff) ? '0 : SW'(seq_site + 1'b1);
            state_nxt     = S_RD_ME;
          end
        end
      end
      S_RECOUNT: begin
        // Reads are issued one a cycle; the registered data lands in the next cycle.
        if (rc_pend_r) begin
          dc_nxt = dc_r + LW'(rd_data_r);
        end
        if (chain_wr) begin
          cnt_nxt     = '0;
          rc_pend_nxt = 1'b0;
          dc_nxt      = '0;
        end else if (cnt_r < n_eff) begin
          mem_ra      = cnt_r[SW-1:0];
          cnt_nxt     = cnt_r + 1'b1;
          rc_pend_nxt = 1'b1;
        end else begin
          rc_pend_nxt = 1'b0;
          if (!rc_pend_r) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_MOD: begin
        if (mod_stat.done) begin
          site_nxt  = SW'(mod_rem);
          state_nxt = S_RD_ME;
        end
      end
      S_LOAD_RD: begin
        mem_ra    = SW'(load_site_r);
        state_nxt = S_LOAD_WR;
      end
      S_LOAD_WR: begin
        mem_we   = 1'b1;
        mem_wa   = SW'(load_site_r);
        mem_wd   = load_down_r;
        spin_nxt = load_down_r;
        if (rd_data_r != load_down_r) begin
          dc_nxt = load_down_r ? dc_r + 1'b1 : dc_r - 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_RD_ME: begin
        mem_ra    = site_r;
        state_nxt = S_RD_L;
      end
      S_RD_L: begin
        mem_ra    = left_site;
        me_nxt    = rd_data_r;
        state_nxt = S_RD_R;
      end
      S_RD_R: begin
        mem_ra    = right_site;
        al_l_nxt  = (rd_data_r == me_r);
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        flip_nxt = flip;
        spin_nxt = me_r ^ flip;
        if (flip) begin
          mem_we = 1'b1;
          mem_wa = site_r;
          mem_wd = ~me_r;
          dc_nxt = me_r ? dc_r - 1'b1 : dc_r + 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_ld) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (out_ld) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      cnt_r        <= '0;
      rc_pend_r    <= 1'b0;
      dc_r         <= '0;
      next_site_r  <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      rc_pend_r    <= rc_pend_nxt;
      dc_r         <= dc_nxt;
      next_site_r  <= next_site_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    load_site_r <= load_site_nxt;
    load_down_r <= load_down_nxt;
    acc_r       <= acc_nxt;
    site_r      <= site_nxt;
    me_r        <= me_nxt;
    al_l_r      <= al_l_nxt;
    spin_r      <= spin_nxt;
    flip_r      <= flip_nxt;
    stat_r      <= stat_nxt;
    if (out_ld) begin
      out_tdata_r <= {MAGN_W'(magn), flip_r, spin_r,
                      (kind_r == KIND_TRIAL) ? SITE_W'(site_r) : load_site_r};
      out_tuser_r <= stat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      spin_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= spin_mem[mem_ra];
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("ready right after an accepted request");
  a_mod_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    mod_stat.done |-> (state_r == S_MOD))
    else $error("remainder finished while the sequencer was not waiting");
  a_decide_mod_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE) |-> !mod_stat.busy)
    else $error("trial decided while the remainder unit still runs");
  a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[11:10] == 2'b00))
    else $error("rejected load reports a spin or a flip");
`endif

endmodule

`default_nettype wire

@@ bench/ising_chain_metropolis_update_unit_test.sv @@
// Self-checking bench for the Ising chain Metropolis update unit: a directed table
// followed by random phases, results checked by a behavioral model or known rows.
// Depends on icmu_pkg and ising_chain_metropolis_update_unit.
module ising_chain_metropolis_update_unit_test;
  import icmu_pkg::*;

  localparam int MAX_SITES    = 1024;
  localparam int IDLE_PCT     = 22;
  localparam int STALL_LIMIT  = 5000;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 75;
  localparam int DRAIN_CYCLES = 50;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_BAD_SITE = 1'b1;

  // Indexes that decode to no register.
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [SITE_W-1:0] site;
    logic              spin_down;
    logic              flipped;
    logic [MAGN_W-1:0] magnetization;
    logic              status;
  } result_t;

  typedef enum logic {ROW_REQUEST, ROW_WRITE} row_op_t;

  typedef struct packed {
    row_op_t                 op;
    logic                    kind;
    logic [SITE_W-1:0]       load_site;
    logic                    load_down;
    logic [RAND_IN_W-1:0]    site_random;
    logic [RAND_IN_W-1:0]    accept_random;
    logic [CFG_ADDR_W-1:0]   reg_index;
    logic [THRESH_W-1:0]     reg_value;
    logic                    known;
    result_t                 want;
  } plan_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata;
  logic                    in_tuser;
  logic                    out_tvalid;
  logic                    out_tready;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    out_tuser;
  logic                    cfg_we;
  logic [CFG_ADDR_W-1:0]   cfg_addr;
  logic [THRESH_W-1:0]     cfg_wdata;

  ising_chain_metropolis_update_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: spin memory, sequential cursor, down-spin count and registers.
  logic                 spin_down_at [MAX_SITES];
  int unsigned          trial_cursor;
  int unsigned          down_spins;
  logic [CHAIN_W-1:0]   chain_reg;
  logic                 mode_reg;
  logic [THRESH_W-1:0]  thr_aligned;
  logic [THRESH_W-1:0]  thr_mixed;
  logic [THRESH_W-1:0]  thr_anti;

  result_t expected_results[$];
  int      mismatches;
  int      quiet_cycles;
  bit      steady;

  function automatic int unsigned chain_sites();
    if (chain_reg < 3) return 3;
    if (chain_reg > MAX_SITES) return MAX_SITES;
    return chain_reg;
  endfunction

  function automatic logic [MAGN_W-1:0] magnetization_now();
    return MAGN_W'(int'(chain_sites()) - 2 * int'(down_spins));
  endfunction

  function automatic void apply_register(logic [CFG_ADDR_W-1:0] index,
                                         logic [THRESH_W-1:0] value);
    case (index)
      CFG_CHAIN_LENGTH: begin
        chain_reg = value[CHAIN_W-1:0];
        // Sites beyond the new chain keep their spins but drop out of the count.
        down_spins = 0;
        for (int i = 0; i < chain_sites(); i++) down_spins += spin_down_at[i];
      end
      CFG_UPDATE_MODE:    mode_reg = value[0];
      CFG_ACCEPT_ALIGNED: thr_aligned = value;
      CFG_ACCEPT_MIXED:   thr_mixed = value;
      CFG_ACCEPT_ANTI:    thr_anti = value;
      default: ;
    endcase
  endfunction

  function automatic result_t metropolis_step(logic kind, logic [SITE_W-1:0] load_site,
                                              logic load_down,
                                              logic [RAND_IN_W-1:0] site_random,
                                              logic [RAND_IN_W-1:0] accept_random);
    int unsigned         n;
    int unsigned         site;
    int unsigned         left;
    int unsigned         right;
    int unsigned         aligned;
    logic                me;
    logic                flip;
    logic [THRESH_W-1:0] thr;
    n = chain_sites();
    if (kind == KIND_LOAD) begin
      if (load_site >= n)
        return '{load_site, 1'b0, 1'b0, magnetization_now(), STATUS_BAD_SITE};
      if (spin_down_at[load_site] != load_down) begin
        if (load_down) down_spins++;
        else down_spins--;
        spin_down_at[load_site] = load_down;
      end
      return '{load_site, load_down, 1'b0, magnetization_now(), STATUS_OK};
    end
    if (mode_reg) begin
      site = site_random % n;
    end else begin
      site = (trial_cursor < n) ? trial_cursor : 0;
      trial_cursor = (site + 1 == n) ? 0 : site + 1;
    end
    left  = (site == 0) ? n - 1 : site - 1;
    right = (site + 1 == n) ? 0 : site + 1;
    me = spin_down_at[site];
    aligned = (spin_down_at[left] == me) + (spin_down_at[right] == me);
    thr = (aligned == 2) ? thr_aligned : (aligned == 1) ? thr_mixed : thr_anti;
    flip = {1'b0, accept_random} < thr;
    if (flip) begin
      me = !me;
      spin_down_at[site] = me;
      if (me) down_spins++;
      else down_spins--;
    end
    return '{SITE_W'(site), me, flip, magnetization_now(), STATUS_OK};
  endfunction

  function automatic logic [THRESH_W-1:0] random_threshold();
    case ($urandom_range(0, 4))
      0:       return THRESH_ZERO;
      1:       return THRESH_ONE;
      2:       return {THRESH_W{1'b1}};
      default: return {1'b0, $urandom()};
    endcase
  endfunction

  function automatic plan_row_t request_row(logic kind, logic [SITE_W-1:0] load_site,
                                            logic load_down,
                                            logic [RAND_IN_W-1:0] site_random,
                                            logic [RAND_IN_W-1:0] accept_random);
    plan_row_t r;
    r = '0;
    r.op = ROW_REQUEST;
    r.kind = kind;
    r.load_site = load_site;
    r.load_down = load_down;
    r.site_random = site_random;
    r.accept_random = accept_random;
    return r;
  endfunction

  function automatic plan_row_t register_row(logic [CFG_ADDR_W-1:0] index,
                                             logic [THRESH_W-1:0] value);
    plan_row_t r;
    r = '0;
    r.op = ROW_WRITE;
    r.reg_index = index;
    r.reg_value = value;
    return r;
  endfunction

  function automatic plan_row_t known_row(plan_row_t r, result_t want);
    r.known = 1'b1;
    r.want = want;
    return r;
  endfunction

  // Offers one request and waits for it to be taken. The predictor always runs so
  // its state stays in step, even when a hand-written expectation is used instead.
  task automatic push_request(logic kind, logic [SITE_W-1:0] load_site, logic load_down,
                              logic [RAND_IN_W-1:0] site_random,
                              logic [RAND_IN_W-1:0] accept_random,
                              logic known, result_t want);
    result_t predicted;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= IN_TDATA_W'({accept_random, site_random, load_down, load_site});
    do @(posedge clk); while (!in_tready);
    predicted = metropolis_step(kind, load_site, load_down, site_random, accept_random);
    expected_results.push_back(known ? want : predicted);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_ADDR_W-1:0] index, logic [THRESH_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    apply_register(index, value);
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (out_tvalid && out_tready) begin
      got = {out_tdata[SITE_W-1:0], out_tdata[10], out_tdata[11], out_tdata[23:12],
             out_tuser};
      if (expected_results.size() == 0) begin
        $error("result with no request pending: site %0d", got.site);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (got.site != want.site) begin
          $error("site: expected %0d, got %0d", want.site, got.site);
          mismatches++;
        end
        if (got.spin_down != want.spin_down) begin
          $error("spin_down: expected %0d, got %0d", want.spin_down, got.spin_down);
          mismatches++;
        end
        if (got.flipped != want.flipped) begin
          $error("flipped: expected %0d, got %0d", want.flipped, got.flipped);
          mismatches++;
        end
        if (got.magnetization != want.magnetization) begin
          $error("magnetization: expected %0d, got %0d", $signed(want.magnetization),
                 $signed(got.magnetization));
          mismatches++;
        end
        if (got.status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          mismatches++;
        end
      end
    end
    out_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("ising_chain_metropolis_update_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    plan_row_t              directed_plan[$];
    plan_row_t              row;
    int unsigned            n;
    logic                   kind;
    logic [SITE_W-1:0]      load_site;
    logic [RAND_IN_W-1:0]   site_random;
    logic [RAND_IN_W-1:0]   accept_random;
    logic [CHAIN_W-1:0]     chain_pick;

    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = KIND_LOAD;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = CFG_CHAIN_LENGTH;
    cfg_wdata = '0;
    mismatches = 0;
    quiet_cycles = 0;
    steady = 1'b0;
    for (int i = 0; i < MAX_SITES; i++) spin_down_at[i] = 1'b0;
    trial_cursor = 0;
    down_spins = 0;
    chain_reg = CHAIN_LEN_RST;
    mode_reg = 1'b0;
    thr_aligned = THRESH_ZERO;
    thr_mixed = THRESH_ONE;
    thr_anti = THRESH_ONE;

    // Reset settings: full chain, sequential order, aligned sites never flip.
    directed_plan.push_back(known_row(request_row(KIND_TRIAL, 10'd0, 1'b0, '0, '0),
                            '{10'd0, 1'b0, 1'b0, 12'd1024, STATUS_OK}));
    directed_plan.push_back(known_row(request_row(KIND_LOAD, 10'd1023, 1'b1, '1, '1),
                            '{10'd1023, 1'b1, 1'b0, 12'd1022, STATUS_OK}));
    directed_plan.push_back(request_row(KIND_TRIAL, 10'd0, 1'b0, '1, '1));
    directed_plan.push_back(request_row(KIND_LOAD, 10'd0, 1'b1, '0, '0));
    directed_plan.push_back(request_row(KIND_TRIAL, 10'd0, 1'b0, '0, '0));
    directed_plan.push_back(request_row(KIND_LOAD, 10'd3, 1'b1, '0, '0));
    // Both neighbors oppose the down spin at site 3, so it flips.
    directed_plan.push_back(request_row(KIND_TRIAL, 10'd0, 1'b0, '0, '1));
    directed_plan.push_back(request_row(KIND_LOAD, 10'd5, 1'b1, '0, '0));
    directed_plan.push_back(request_row(KIND_TRIAL, 10'd0, 1'b0, '0, '1));
    directed_plan.push_back(register_row(CFG_ACCEPT_ALIGNED, {THRESH_W{1'b1}}));
    directed_plan.push_back(register_row(CFG_ACCEPT_MIXED, THRESH_ZERO));
    directed_plan.push_back(register_row(CFG_ACCEPT_ANTI, 33'h0_FFFF_FFFF));
    directed_plan.push_back(register_row(CFG_UPDATE_MODE, 33'd1));
    // A length below the minimum acts as three sites, of which only site 0 is down.
    directed_plan.push_back(register_row(CFG_CHAIN_LENGTH, 33'd0));
    directed_plan.push_back(known_row(request_row(KIND_LOAD, 10'd1023, 1'b0, '0, '0),
                            '{10'd1023, 1'b0, 1'b0, 12'd1, STATUS_BAD_SITE}));
    directed_plan.push_back(known_row(request_row(KIND_LOAD, 10'd3, 1'b1, '0, '0),
                            '{10'd3, 1'b0, 1'b0, 12'd1, STATUS_BAD_SITE}));
    directed_plan.push_back(request_row(KIND_TRIAL, 10'd0, 1'b0, '1, '1));
    directed_plan.push_back(request_row(KIND_TRIAL, 10'd0, 1'b0, '0, 32'hFFFF_FFFE));
    directed_plan.push_back(request_row(KIND_TRIAL, 10'd0, 1'b0, 32'h8000_0001, '0));
    // Back to sequential order: the cursor now lies beyond the chain.
    directed_plan.push_back(register_row(CFG_UPDATE_MODE, 33'd0));
    directed_plan.push_back(request_row(KIND_TRIAL, 10'd0, 1'b0, '0, 32'h7FFF_FFFF));
    directed_plan.push_back(request_row(KIND_TRIAL, 10'd0, 1'b0, '0, '0));
    directed_plan.push_back(request_row(KIND_TRIAL, 10'd0, 1'b0, '0, '1));
    directed_plan.push_back(register_row(CFG_SPARE_FIRST, {THRESH_W{1'b1}}));
    directed_plan.push_back(register_row(CFG_SPARE_LAST, '0));
    // Above the maximum the chain spans all sites; spins kept outside count again.
    directed_plan.push_back(register_row(CFG_CHAIN_LENGTH, 33'h7FF));
    directed_plan.push_back(request_row(KIND_LOAD, 10'd1023, 1'b0, '0, '0));
    directed_plan.push_back(request_row(KIND_TRIAL, 10'd0, 1'b0, '0, '0));
    directed_plan.push_back(request_row(KIND_LOAD, 10'd512, 1'b1, '0, '0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.op == ROW_WRITE) begin
        settle();
        write_register(row.reg_index, row.reg_value);
      end else begin
        push_request(row.kind, row.load_site, row.load_down, row.site_random,
                     row.accept_random, row.known, row.want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      steady = (phase == 2);
      if (phase == 0) chain_pick = 11'd3;
      else if (phase == PHASES - 1) chain_pick = CHAIN_W'(MAX_SITES);
      else begin
        case ($urandom_range(0, 3))
          0:       chain_pick = CHAIN_W'($urandom_range(0, 2));
          1:       chain_pick = CHAIN_W'($urandom_range(4, 24));
          2:       chain_pick = CHAIN_W'($urandom_range(25, MAX_SITES - 1));
          default: chain_pick = CHAIN_W'($urandom_range(MAX_SITES + 1, 2047));
        endcase
      end
      write_register(CFG_UPDATE_MODE, THRESH_W'(phase % 2));
      write_register(CFG_ACCEPT_ALIGNED, random_threshold());
      write_register(CFG_ACCEPT_MIXED, random_threshold());
      write_register(CFG_ACCEPT_ANTI, random_threshold());
      if ($urandom_range(0, 2) == 0)
        write_register(CFG_ACCEPT_ANTI + CFG_ADDR_W'($urandom_range(1, 3)),
                       THRESH_W'($urandom()));
      // The chain length goes last, since it starts a recount inside the block.
      write_register(CFG_CHAIN_LENGTH, THRESH_W'(chain_pick));

      for (int item = 0; item < PHASE_ITEMS; item++) begin
        n = chain_sites();
        kind = ($urandom_range(0, 99) < 35) ? KIND_LOAD : KIND_TRIAL;
        case ($urandom_range(0, 9))
          0:       load_site = SITE_W'($urandom());
          1:       load_site = (n < MAX_SITES) ? SITE_W'($urandom_range(n, MAX_SITES - 1))
                                                : SITE_W'($urandom());
          default: load_site = SITE_W'($urandom_range(0, n - 1));
        endcase
        site_random = ($urandom_range(0, 9) == 0) ? {RAND_IN_W{$urandom_range(0, 1) == 1}}
                                                  : $urandom();
        accept_random = ($urandom_range(0, 9) == 0) ? {RAND_IN_W{$urandom_range(0, 1) == 1}}
                                                    : $urandom();
        push_request(kind, load_site, $urandom_range(0, 1) == 1, site_random, accept_random,
                     1'b0, '0);
      end
    end

    settle();
    steady = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("ising_chain_metropolis_update_unit test passed");
    end else begin
      $display("ising_chain_metropolis_update_unit test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/icmu_pkg.sv
sv/icmu_mod_unit.sv
sv/ising_chain_metropolis_update_unit.sv
bench/ising_chain_metropolis_update_unit_test.sv
